/* design/sestab_pkg.sv */
package sestab_pkg;

    localparam int ADDR_W = 32;
    localparam int TIME_W = 32;
    localparam int OP_W = 2;
    localparam int OUT_IDX_W = 3;
    localparam int OUT_CNT_W = 3;
    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd300000;

    typedef enum logic [OP_W-1:0] {
        OP_LOGIN  = 2'd0,
        OP_CHECK  = 2'd1,
        OP_TOUCH  = 2'd2,
        OP_LOGOUT = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPIRE,
        ST_LOOKUP,
        ST_SCAN,
        ST_UPDATE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load_req;
        logic expire_step;
        logic lookup;
        logic scan_step;
        logic update;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic need_scan;
        logic idx_last;
        logic out_busy;
    } t_stat;

endpackage

/* design/sestab_ctrl.sv */
module sestab_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [1:0]           i_op,
    input  sestab_pkg::t_stat    i_stat,
    output sestab_pkg::t_cmd     o_cmd,
    output logic                 o_in_ready
);

    sestab_pkg::t_state r_state;
    sestab_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sestab_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sestab_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == sestab_pkg::OP_CHECK) begin
                        n_state = sestab_pkg::ST_EXPIRE;
                    end else begin
                        n_state = sestab_pkg::ST_LOOKUP;
                    end
                end
            end
            sestab_pkg::ST_EXPIRE: begin
                if (i_stat.idx_last) begin
                    n_state = sestab_pkg::ST_LOOKUP;
                end
            end
            sestab_pkg::ST_LOOKUP: begin
                if (i_stat.need_scan) begin
                    n_state = sestab_pkg::ST_SCAN;
                end else begin
                    n_state = sestab_pkg::ST_UPDATE;
                end
            end
            sestab_pkg::ST_SCAN: begin
                if (i_stat.idx_last) begin
                    n_state = sestab_pkg::ST_UPDATE;
                end
            end
            sestab_pkg::ST_UPDATE: begin
                n_state = sestab_pkg::ST_FINISH;
            end
            sestab_pkg::ST_FINISH: begin
                if (!i_stat.out_busy) begin
                    n_state = sestab_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sestab_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            sestab_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load_req = i_in_valid;
            end
            sestab_pkg::ST_EXPIRE: begin
                o_cmd.expire_step = 1'b1;
            end
            sestab_pkg::ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
            end
            sestab_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            sestab_pkg::ST_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            sestab_pkg::ST_FINISH: begin
                o_cmd.load_out = !i_stat.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* design/sestab_dp.sv */
module sestab_dp #(
    parameter int SLOTS = 5
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  sestab_pkg::t_cmd                       i_cmd,
    output sestab_pkg::t_stat                      o_stat,
    input  logic [1:0]                             i_op,
    input  logic [sestab_pkg::ADDR_W-1:0]          i_client_address,
    input  logic                                   i_credentials_ok,
    input  logic [sestab_pkg::TIME_W-1:0]          i_now_ms,
    input  logic [sestab_pkg::TIME_W-1:0]          i_timeout,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic                                   o_success,
    output logic [sestab_pkg::OUT_IDX_W-1:0]       o_slot_index,
    output logic                                   o_evicted,
    output logic [sestab_pkg::OUT_CNT_W-1:0]       o_expired_count,
    output logic [sestab_pkg::OUT_CNT_W-1:0]       o_active_count
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

    sestab_pkg::t_op                    r_op;
    logic [sestab_pkg::ADDR_W-1:0]      r_addr;
    logic                               r_cred;
    logic [sestab_pkg::TIME_W-1:0]      r_now;

    logic [SLOTS-1:0]                   r_valid;
    logic [sestab_pkg::ADDR_W-1:0]      r_ent_addr [SLOTS];
    logic [sestab_pkg::TIME_W-1:0]      r_ent_time [SLOTS];

    logic [IDX_W-1:0]                   r_idx;
    logic [CNT_W-1:0]                   r_expired;
    logic [CNT_W-1:0]                   r_active;

    logic                               r_hit;
    logic [IDX_W-1:0]                   r_hit_idx;
    logic                               r_free;
    logic [IDX_W-1:0]                   r_free_idx;
    logic [IDX_W-1:0]                   r_best_idx;
    logic [sestab_pkg::TIME_W-1:0]      r_best_time;

    logic                               r_res_success;
    logic [IDX_W-1:0]                   r_res_slot;
    logic                               r_res_evicted;

    logic                               r_out_valid;
    logic                               r_out_success;
    logic [sestab_pkg::OUT_IDX_W-1:0]   r_out_slot;
    logic                               r_out_evicted;
    logic [sestab_pkg::OUT_CNT_W-1:0]   r_out_expired;
    logic [sestab_pkg::OUT_CNT_W-1:0]   r_out_active;

    logic [SLOTS-1:0]                   match_vec;
    logic                               match_any;
    logic [IDX_W-1:0]                   match_idx;
    logic                               free_any;
    logic [IDX_W-1:0]                   free_idx;
    logic [sestab_pkg::TIME_W-1:0]      cur_time;
    logic [sestab_pkg::TIME_W-1:0]      idle_time;
    logic                               cur_expire;
    logic                               scan_take;
    logic                               login_ok;
    logic [IDX_W-1:0]                   tgt_idx;

    always_comb begin
        match_any = 1'b0;
        match_idx = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            match_vec[i] = r_valid[i] && (r_ent_addr[i] == r_addr);
            if (match_vec[i]) begin
                match_any = 1'b1;
                match_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign cur_time = r_ent_time[r_idx];
    assign idle_time = r_now - cur_time;
    assign cur_expire = r_valid[r_idx] && (idle_time > i_timeout);
    assign scan_take = (r_idx == '0) || (cur_time < r_best_time);
    assign login_ok = (r_op == sestab_pkg::OP_LOGIN) && r_cred;
    assign tgt_idx = r_hit ? r_hit_idx : (r_free ? r_free_idx : r_best_idx);

    assign o_stat.need_scan = login_ok && !match_any && !free_any;
    assign o_stat.idx_last = (r_idx == IDX_LAST);
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op <= sestab_pkg::t_op'(i_op);
            r_addr <= i_client_address;
            r_cred <= i_credentials_ok;
            r_now <= i_now_ms;
        end
        if (i_cmd.lookup) begin
            r_hit <= match_any;
            r_hit_idx <= match_idx;
            r_free <= free_any;
            r_free_idx <= free_idx;
        end
        if (i_cmd.scan_step && scan_take) begin
            r_best_idx <= r_idx;
            r_best_time <= cur_time;
        end
        if (i_cmd.update) begin
            if (login_ok) begin
                r_ent_addr[tgt_idx] <= r_addr;
                r_ent_time[tgt_idx] <= r_now;
            end else if (r_hit && (r_op == sestab_pkg::OP_TOUCH)) begin
                r_ent_time[r_hit_idx] <= r_now;
            end
        end
        if (i_cmd.update) begin
            if (login_ok) begin
                r_res_success <= 1'b1;
                r_res_slot <= tgt_idx;
                r_res_evicted <= !r_hit && !r_free;
            end else begin
                r_res_success <= r_hit && (r_op != sestab_pkg::OP_LOGIN);
                r_res_slot <= (r_hit && (r_op != sestab_pkg::OP_LOGIN)) ? r_hit_idx : '0;
                r_res_evicted <= 1'b0;
            end
        end
        if (i_cmd.load_out) begin
            r_out_success <= r_res_success;
            r_out_slot <= sestab_pkg::OUT_IDX_W'(r_res_slot);
            r_out_evicted <= r_res_evicted;
            r_out_expired <= sestab_pkg::OUT_CNT_W'(r_expired);
            r_out_active <= sestab_pkg::OUT_CNT_W'(r_active);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_idx <= '0;
            r_expired <= '0;
            r_active <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_req || i_cmd.lookup) begin
                r_idx <= '0;
            end else if (i_cmd.expire_step || i_cmd.scan_step) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.load_req) begin
                r_expired <= '0;
            end else if (i_cmd.expire_step && cur_expire) begin
                r_expired <= r_expired + 1'b1;
            end
            if (i_cmd.expire_step && cur_expire) begin
                r_valid[r_idx] <= 1'b0;
                r_active <= r_active - 1'b1;
            end else if (i_cmd.update) begin
                if (login_ok) begin
                    r_valid[tgt_idx] <= 1'b1;
                    if (!r_hit && r_free) begin
                        r_active <= r_active + 1'b1;
                    end
                end else if (r_hit && (r_op == sestab_pkg::OP_LOGOUT)) begin
                    r_valid[r_hit_idx] <= 1'b0;
                    r_active <= r_active - 1'b1;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_success = r_out_success;
    assign o_slot_index = r_out_slot;
    assign o_evicted = r_out_evicted;
    assign o_expired_count = r_out_expired;
    assign o_active_count = r_out_active;

endmodule

/* design/session_table_lru_idle_timeout.sv */
// Session table of SLOTS entries keyed by a 32-bit client address, with login, check,
// touch and logout requests, one result word per request word. A request word is taken
// only while the block is idle. Login, touch and logout go through the lookup, update and
// finish states; the result is loaded into the output register as the block leaves finish,
// and the next word can be taken once it is back in idle. A check first goes through the
// expiry state, where idle-timeout expiry walks the entry registers one slot per cycle.
// A login that finds neither its address nor a free slot also goes through a scan state,
// where the search for the smallest last-activity time walks the slots one per cycle as
// well. A result that is not yet taken holds the block in its final state until the output
// register frees up. The timeout register sits at APB address 0 and resets to 300000.
module session_table_lru_idle_timeout #(
    parameter int SLOTS = 5
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_op,
    input  logic [31:0]                           i_client_address,
    input  logic                                  i_credentials_ok,
    input  logic [31:0]                           i_now_ms,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_success,
    output logic [2:0]                            o_slot_index,
    output logic                                  o_evicted,
    output logic [2:0]                            o_expired_count,
    output logic [2:0]                            o_active_count,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    sestab_pkg::t_cmd                  cmd;
    sestab_pkg::t_stat                 stat;
    logic [sestab_pkg::TIME_W-1:0]     r_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= sestab_pkg::TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_timeout <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? '0 : r_timeout;

    sestab_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    sestab_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_op             (i_op),
        .i_client_address (i_client_address),
        .i_credentials_ok (i_credentials_ok),
        .i_now_ms         (i_now_ms),
        .i_timeout        (r_timeout),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_success        (o_success),
        .o_slot_index     (o_slot_index),
        .o_evicted        (o_evicted),
        .o_expired_count  (o_expired_count),
        .o_active_count   (o_active_count)
    );

endmodule

/* verif/session_table_checker.sv */
`timescale 1ns / 1ps

module session_table_checker #(
    parameter int SLOTS = 5,
    parameter logic [2:0] TIMEOUT_ADDR = 3'd0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_client_address,
    input  logic        i_credentials_ok,
    input  logic [31:0] i_now_ms,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_success,
    input  logic [2:0]  i_slot_index,
    input  logic        i_evicted,
    input  logic [2:0]  i_expired_count,
    input  logic [2:0]  i_active_count,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    output int          o_error_count,
    output int          o_pending
);

    typedef struct packed {
        logic       success;
        logic [2:0] slot;
        logic       evicted;
        logic [2:0] expired;
        logic [2:0] active;
    } t_session_result;

    logic [31:0]     idle_limit;
    logic            slot_valid [SLOTS];
    logic [31:0]     slot_addr [SLOTS];
    logic [31:0]     slot_seen [SLOTS];
    t_session_result expected_results [$];
    int              error_count = 0;

    initial begin
        o_error_count = 0;
        o_pending = 0;
    end

    function automatic int find_slot(logic [31:0] addr);
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i] && slot_addr[i] == addr) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_session_result session_apply(sestab_pkg::t_op op, logic [31:0] addr,
                                                      logic cred, logic [31:0] now);
        t_session_result r;
        int              hit;
        int              expired;
        int              active;
        logic [31:0]     idle;
        r = '0;
        expired = 0;
        active = 0;
        if (op == sestab_pkg::OP_LOGIN) begin
            if (cred) begin
                hit = find_slot(addr);
                if (hit < 0) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!slot_valid[i]) begin
                            hit = i;
                            break;
                        end
                    end
                end
                if (hit < 0) begin
                    hit = 0;
                    for (int i = 1; i < SLOTS; i++) begin
                        if (slot_seen[i] < slot_seen[hit]) begin
                            hit = i;
                        end
                    end
                    r.evicted = 1'b1;
                end
                slot_valid[hit] = 1'b1;
                slot_addr[hit] = addr;
                slot_seen[hit] = now;
                r.success = 1'b1;
                r.slot = hit[2:0];
            end
        end else begin
            if (op == sestab_pkg::OP_CHECK) begin
                for (int i = 0; i < SLOTS; i++) begin
                    idle = now - slot_seen[i];
                    if (slot_valid[i] && idle > idle_limit) begin
                        slot_valid[i] = 1'b0;
                        expired++;
                    end
                end
            end
            hit = find_slot(addr);
            if (hit >= 0) begin
                r.success = 1'b1;
                r.slot = hit[2:0];
                if (op == sestab_pkg::OP_TOUCH) begin
                    slot_seen[hit] = now;
                end else if (op == sestab_pkg::OP_LOGOUT) begin
                    slot_valid[hit] = 1'b0;
                end
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i]) begin
                active++;
            end
        end
        r.expired = expired[2:0];
        r.active = active[2:0];
        return r;
    endfunction

    task automatic report_failure(input string what);
        error_count++;
        if (error_count <= 10) begin
            $display("[%0t] %s", $time, what);
        end
    endtask

    always @(posedge i_clk) begin
        t_session_result got;
        t_session_result want;
        if (!i_rst_n) begin
            idle_limit = sestab_pkg::TIMEOUT_RESET;
            for (int i = 0; i < SLOTS; i++) begin
                slot_valid[i] = 1'b0;
                slot_addr[i] = '0;
                slot_seen[i] = '0;
            end
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = {i_success, i_slot_index, i_evicted, i_expired_count, i_active_count};
                if (expected_results.size() == 0) begin
                    report_failure($sformatf("result word with nothing expected: %p", got));
                end else begin
                    want = expected_results.pop_front();
                    if (got.success !== want.success || got.slot !== want.slot ||
                        got.evicted !== want.evicted || got.expired !== want.expired ||
                        got.active !== want.active) begin
                        report_failure($sformatf("result mismatch: expected %p, got %p",
                                                 want, got));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(session_apply(sestab_pkg::t_op'(i_op),
                                                         i_client_address,
                                                         i_credentials_ok, i_now_ms));
            end
            if (i_psel && i_penable && i_pready && i_paddr == TIMEOUT_ADDR) begin
                if (i_pwrite) begin
                    idle_limit = i_pwdata;
                end else if (i_prdata !== idle_limit) begin
                    report_failure($sformatf("timeout readback: expected %0d, got %0d",
                                             idle_limit, i_prdata));
                end
            end
        end
        o_error_count <= error_count;
        o_pending <= expected_results.size();
    end

endmodule

/* verif/tb_session_table_lru_idle_timeout.sv */
`timescale 1ns / 1ps

module tb_session_table_lru_idle_timeout;

    localparam logic [2:0] TIMEOUT_ADDR = 3'd0;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_op = sestab_pkg::OP_LOGIN;
    logic [31:0] i_client_address = '0;
    logic        i_credentials_ok = 1'b0;
    logic [31:0] i_now_ms = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_success;
    logic [2:0]  o_slot_index;
    logic        o_evicted;
    logic [2:0]  o_expired_count;
    logic [2:0]  o_active_count;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          error_count;
    int          pending_words;
    int          burst_left = 0;
    logic [31:0] clock_ms = '0;

    always #2 i_clk = ~i_clk;

    session_table_lru_idle_timeout i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_op             (i_op),
        .i_client_address (i_client_address),
        .i_credentials_ok (i_credentials_ok),
        .i_now_ms         (i_now_ms),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_success        (o_success),
        .o_slot_index     (o_slot_index),
        .o_evicted        (o_evicted),
        .o_expired_count  (o_expired_count),
        .o_active_count   (o_active_count),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    session_table_checker #(
        .TIMEOUT_ADDR (TIMEOUT_ADDR)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_op             (i_op),
        .i_client_address (i_client_address),
        .i_credentials_ok (i_credentials_ok),
        .i_now_ms         (i_now_ms),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_success        (o_success),
        .i_slot_index     (o_slot_index),
        .i_evicted        (o_evicted),
        .i_expired_count  (o_expired_count),
        .i_active_count   (o_active_count),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_prdata         (prdata),
        .i_pready         (pready),
        .o_error_count    (error_count),
        .o_pending        (pending_words)
    );

    task automatic send_word(input sestab_pkg::t_op op, input logic [31:0] addr,
                             input logic cred, input logic [31:0] now);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        i_in_valid = 1'b1;
        i_op = op;
        i_client_address = addr;
        i_credentials_ok = cred;
        i_now_ms = now;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid = 1'b0;
        while (pending_words != 0) @(negedge i_clk);
        repeat (24) @(negedge i_clk);
    endtask

    task automatic apb_access(input logic write, input logic [2:0] addr, input logic [31:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = write;
        paddr = addr;
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic run_random(input int count, input logic [31:0] limit);
        logic [31:0]     pool [8];
        logic [31:0]     span;
        logic [31:0]     addr;
        sestab_pkg::t_op op;
        int              pick;
        span = (limit > 32'h7FFF_FFFE) ? 32'hFFFF_FFFF : limit * 2 + 2;
        foreach (pool[k]) pool[k] = $urandom;
        pool[0] = 32'h0000_0000;
        pool[1] = 32'hFFFF_FFFF;
        repeat (count) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: clock_ms += $urandom_range(0, 64);
                6, 7: clock_ms += $urandom_range(0, span);
                8: clock_ms = $urandom;
                default: ;
            endcase
            pick = $urandom_range(0, 19);
            if (pick < 7) begin
                op = sestab_pkg::OP_LOGIN;
            end else if (pick < 12) begin
                op = sestab_pkg::OP_CHECK;
            end else if (pick < 16) begin
                op = sestab_pkg::OP_TOUCH;
            end else begin
                op = sestab_pkg::OP_LOGOUT;
            end
            addr = ($urandom_range(0, 4) == 0) ? $urandom : pool[$urandom_range(0, 7)];
            send_word(op, addr, $urandom_range(0, 6) != 0, clock_ms);
        end
    endtask

    initial begin
        int words_taken;
        int hold_left;
        int next_hold;
        int mode;
        int mode_left;
        words_taken = 0;
        hold_left = 0;
        next_hold = 400;
        mode = 0;
        mode_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                words_taken++;
            end
            @(negedge i_clk);
            if (hold_left == 0 && words_taken >= next_hold) begin
                hold_left = 300;
                next_hold += 600;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else begin
                case (mode)
                    0: i_out_ready = 1'b1;
                    1: i_out_ready = $urandom_range(0, 1);
                    2: i_out_ready = ($urandom_range(0, 3) == 0);
                    default: i_out_ready = ~i_out_ready;
                endcase
            end
        end
    end

    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [31:0] phase_limit [5];
        phase_limit = '{32'd0, 32'hFFFF_FFFF, 32'd1000, sestab_pkg::TIMEOUT_RESET, 32'd0};
        phase_limit[4] = $urandom_range(1, 5000);
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_word(sestab_pkg::OP_CHECK, 32'h0000_0000, 1'b0, 32'd0);
        send_word(sestab_pkg::OP_LOGIN, 32'h0000_0001, 1'b0, 32'd10);
        send_word(sestab_pkg::OP_TOUCH, 32'hFFFF_FFFF, 1'b1, 32'd10);
        send_word(sestab_pkg::OP_LOGOUT, 32'hFFFF_FFFF, 1'b1, 32'd10);
        send_word(sestab_pkg::OP_LOGIN, 32'h0000_0000, 1'b1, 32'd100);
        send_word(sestab_pkg::OP_LOGIN, 32'hFFFF_FFFF, 1'b1, 32'd50);
        send_word(sestab_pkg::OP_LOGIN, 32'hA5A5_A5A5, 1'b1, 32'd200);
        send_word(sestab_pkg::OP_LOGIN, 32'h5A5A_5A5A, 1'b1, 32'd50);
        send_word(sestab_pkg::OP_LOGIN, 32'h1234_5678, 1'b1, 32'd300);
        send_word(sestab_pkg::OP_LOGIN, 32'h1234_5678, 1'b1, 32'd400);
        send_word(sestab_pkg::OP_LOGIN, 32'hDEAD_BEEF, 1'b1, 32'd500);
        send_word(sestab_pkg::OP_LOGIN, 32'h0BAD_F00D, 1'b1, 32'd600);
        send_word(sestab_pkg::OP_LOGIN, 32'h0000_0000, 1'b0, 32'd700);
        send_word(sestab_pkg::OP_TOUCH, 32'h0000_0000, 1'b0, 32'hFFFF_FFF0);
        send_word(sestab_pkg::OP_TOUCH, 32'hA5A5_A5A5, 1'b1, 32'hFFFF_FFFF);
        send_word(sestab_pkg::OP_CHECK, 32'h0000_0000, 1'b1, 32'h0000_0010);
        send_word(sestab_pkg::OP_CHECK, 32'hA5A5_A5A5, 1'b0, 32'h0000_0010);
        send_word(sestab_pkg::OP_LOGOUT, 32'h0000_0000, 1'b1, 32'h0000_0020);
        send_word(sestab_pkg::OP_LOGOUT, 32'h0000_0000, 1'b1, 32'h0000_0020);
        send_word(sestab_pkg::OP_LOGIN, 32'h7FFF_FFFF, 1'b1, 32'h0000_0020);
        send_word(sestab_pkg::OP_CHECK, 32'h1234_5678, 1'b1, 32'h0000_0030);
        clock_ms = 32'h0000_0040;

        foreach (phase_limit[p]) begin
            drain_results();
            apb_access(1'b1, TIMEOUT_ADDR, phase_limit[p]);
            apb_access(1'b0, TIMEOUT_ADDR, 32'h0);
            run_random(287, phase_limit[p]);
        end
        drain_results();

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* sim.f */
design/sestab_pkg.sv
design/sestab_ctrl.sv
design/sestab_dp.sv
design/session_table_lru_idle_timeout.sv
verif/session_table_checker.sv
verif/tb_session_table_lru_idle_timeout.sv
